### rtl/core/sfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared types and constants of the sensor frame assembler: frame layout,
// register indexes, the register set and the CRC-8 step.
// ----------------------------------------------------------------------------
package sfa_pkg;

  localparam int FRAME_LEN   = 38;
  localparam int FRAME_BITS  = FRAME_LEN * 8;
  localparam int HEADER_LEN  = 26;
  localparam int PAYLOAD_LEN = 4;
  localparam int ADDR_LEN    = 4;
  localparam int EUI_LEN     = 8;
  localparam int POS_W       = 6;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int SAMPLE_W    = 32;

  localparam logic [POS_W-1:0] POS_LAST      = POS_W'(FRAME_LEN - 1);
  // Payload occupies bytes 31..34, CRC follows at byte 35.
  localparam logic [POS_W-1:0] POS_PAY_FIRST = POS_W'(31);
  localparam logic [POS_W-1:0] POS_PAY_LAST  = POS_W'(34);

  localparam logic [7:0] CRC_POLY = 8'h07;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEVICE_ADDRESS  = 4'd0,
    REG_DEVICE_EUI      = 4'd1,
    REG_APPLICATION_EUI = 4'd2,
    REG_ADDR_TYPE       = 4'd3,
    REG_DEV_ID_TYPE     = 4'd4,
    REG_APP_ID_TYPE     = 4'd5,
    REG_START_DELIM     = 4'd6,
    REG_END_MARKER      = 4'd7
  } sfa_reg_idx_t;

  localparam logic [7:0]  START_DELIM_RST = 8'd126;
  localparam logic [15:0] END_MARKER_RST  = 16'd3338;

  typedef struct packed {
    logic [31:0] device_address;
    logic [63:0] device_eui;
    logic [63:0] application_eui;
    logic [7:0]  addr_type;
    logic [7:0]  dev_id_type;
    logic [7:0]  app_id_type;
    logic [7:0]  start_delim;
    logic [15:0] end_marker;
  } sfa_cfg_t;

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/sfa_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module sfa_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [sfa_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [sfa_pkg::CFG_DATA_W-1:0] wr_data,
  output sfa_pkg::sfa_cfg_t              cfg
);
  import sfa_pkg::*;

  sfa_cfg_t cfg_r;
  sfa_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_DEVICE_ADDRESS:  cfg_nxt.device_address  = wr_data[31:0];
        REG_DEVICE_EUI:      cfg_nxt.device_eui      = wr_data;
        REG_APPLICATION_EUI: cfg_nxt.application_eui = wr_data;
        REG_ADDR_TYPE:       cfg_nxt.addr_type       = wr_data[7:0];
        REG_DEV_ID_TYPE:     cfg_nxt.dev_id_type     = wr_data[7:0];
        REG_APP_ID_TYPE:     cfg_nxt.app_id_type     = wr_data[7:0];
        REG_START_DELIM:     cfg_nxt.start_delim     = wr_data[7:0];
        REG_END_MARKER:      cfg_nxt.end_marker      = wr_data[15:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address  <= '0;
      cfg_r.device_eui      <= '0;
      cfg_r.application_eui <= '0;
      cfg_r.addr_type       <= '0;
      cfg_r.dev_id_type     <= '0;
      cfg_r.app_id_type     <= '0;
      cfg_r.start_delim     <= START_DELIM_RST;
      cfg_r.end_marker      <= END_MARKER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/sensor_frame_assembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_assembler
// Wraps each 32-bit sample word into a 38-byte frame (delimiter, sizes,
// three TLV fields, payload, CRC-8, end marker), sent one byte per cycle.
//
//   Channel  Handshake              Payload
//   -------  ---------------------  ------------------------------------
//   input    start / busy           in_sample_bits[31:0]
//   result   out_valid (strobe)     out_frame_byte[7:0], out_last_byte
//   config   cfg_valid / cfg_ready  cfg_index[3:0], cfg_data[63:0]
//
// Frames go out one byte per cycle through the single byte output register.
// A taken word passes the holding register, then the frame word register.
// One word waits in a holding register while the current frame goes out, so
// frames follow each other with no gap; busy is high while that register is
// full. Reset is synchronous; it empties the pipeline and restores registers.
// The receiver takes every byte in the cycle it appears.
// ----------------------------------------------------------------------------
module sensor_frame_assembler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [sfa_pkg::SAMPLE_W-1:0]   in_sample_bits,
  output logic                           out_valid,
  output logic [7:0]                     out_frame_byte,
  output logic                           out_last_byte,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sfa_pkg::*;

  sfa_cfg_t cfg;

  // Holding register for the next word.
  logic                pend_valid_r, pend_valid_nxt;
  logic [SAMPLE_W-1:0] pend_r, pend_nxt;
  // Word of the frame in flight and its byte position.
  logic                active_r, active_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [7:0]          crc_r, crc_nxt;
  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic                out_last_r, out_last_nxt;

  logic                  accept;
  logic                  load;
  logic                  at_last;
  logic [FRAME_BITS-1:0] frame_vec;
  logic [7:0]            cur_byte;

  assign cfg_ready = 1'b1;

  sfa_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign busy    = pend_valid_r;
  assign accept  = start && !busy;
  assign at_last = active_r && (pos_r == POS_LAST);
  // Start the next frame when idle or right after the last byte goes out.
  assign load    = pend_valid_r && (!active_r || (pos_r == POS_LAST));

  // Whole frame, first byte in the top bits. The CRC slot takes the running
  // CRC, which holds all four payload bytes by the time it is read.
  assign frame_vec = {cfg.start_delim,
                      16'(HEADER_LEN), 16'(PAYLOAD_LEN),
                      cfg.addr_type, 8'(ADDR_LEN), cfg.device_address,
                      cfg.dev_id_type, 8'(EUI_LEN), cfg.device_eui,
                      cfg.app_id_type, 8'(EUI_LEN), cfg.application_eui,
                      sample_r, crc_r, cfg.end_marker};

  always_comb begin
    if (pos_r <= POS_LAST) begin
      cur_byte = frame_vec[(FRAME_LEN - 1 - int'(pos_r)) * 8 +: 8];
    end else begin
      cur_byte = '0;
    end
  end

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    active_nxt     = active_r;
    pos_nxt        = pos_r;
    sample_nxt     = sample_r;
    crc_nxt        = crc_r;

    // Take the word into the holding register; a load frees it.
    if (accept) begin
      pend_valid_nxt = 1'b1;
      pend_nxt       = in_sample_bits;
    end else if (load) begin
      pend_valid_nxt = 1'b0;
    end

    if (load) begin
      active_nxt = 1'b1;
      pos_nxt    = '0;
      sample_nxt = pend_r;
    end else if (at_last) begin
      active_nxt = 1'b0;
    end else if (active_r) begin
      pos_nxt = pos_r + 1'b1;
    end

    // Fold each payload byte into the CRC as it goes out.
    if (active_r && (pos_r >= POS_PAY_FIRST) && (pos_r <= POS_PAY_LAST)) begin
      crc_nxt = crc8_byte((pos_r == POS_PAY_FIRST) ? 8'h00 : crc_r, cur_byte);
    end

    out_valid_nxt = active_r;
    out_byte_nxt  = cur_byte;
    out_last_nxt  = at_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      active_r     <= 1'b0;
      pos_r        <= '0;
      out_valid_r  <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      active_r     <= active_nxt;
      pos_r        <= pos_nxt;
      out_valid_r  <= out_valid_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    sample_r   <= sample_nxt;
    crc_r      <= crc_nxt;
    out_byte_r <= out_byte_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;

`ifndef SYNTHESIS
  a_last_has_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_byte |-> out_valid)
    else $error("last-byte flag without strobe");

  a_pending_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_valid_r && !active_r) |=> (active_r && (pos_r == '0)))
    else $error("held word not started while idle");

  a_pos_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && (pos_r != POS_LAST)) |=> (active_r && (pos_r == $past(pos_r) + 1'b1)))
    else $error("byte position skipped or stalled");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (pos_r <= POS_LAST))
    else $error("byte position beyond frame");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word not held");
`endif

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sensor_frame_assembler. A queue of sample words
// feeds a clocked driver that raises start with random gaps. Every word the
// block takes is turned into its 38 expected frame bytes right away. A
// clocked monitor compares each strobed byte and its last flag, in order,
// against those bytes. Register settings change only while the block is
// idle, between phases: first the reset values, then all ones, then all
// zeros, then a series of random settings.
// ----------------------------------------------------------------------------
module testbench;
  import sfa_pkg::*;

  localparam int GAP_MAX     = 13;  // longest idle stretch between two words
  localparam int SETTLE_CYC  = 6;   // quiet cycles after the last byte of a phase
  localparam int RAND_PHASES = 6;
  localparam int RAND_WORDS  = 34;  // random words per random phase

  // Words for the first phase: zero, all ones, sign bit, infinities, NaN,
  // denormal and normal limits, and alternating bit patterns.
  localparam logic [SAMPLE_W-1:0] DIRECTED_WORDS [16] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
    32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h3F80_0000,
    32'hBF80_0000, 32'h0080_0000, 32'h007F_FFFF, 32'h7F7F_FFFF,
    32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'hFEDC_BA98
  };

  typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_mode_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  // Local copy of the register set, kept in step with every accepted write.
  typedef struct {
    logic [31:0] dev_addr;
    logic [63:0] dev_eui;
    logic [63:0] app_eui;
    logic [7:0]  addr_type;
    logic [7:0]  dev_type;
    logic [7:0]  app_type;
    logic [7:0]  delim;
    logic [15:0] end_mark;
  } frame_regs_t;

  logic                  clk;
  logic                  rst_n          = 1'b0;
  logic                  start          = 1'b0;
  logic                  busy;
  logic [SAMPLE_W-1:0]   in_sample_bits = '0;
  logic                  out_valid;
  logic [7:0]            out_frame_byte;
  logic                  out_last_byte;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  logic [SAMPLE_W-1:0] pending_samples [$];
  frame_byte_t         expected_bytes  [$];
  frame_regs_t         regs;
  frame_byte_t         want;
  int                  gap_left       = 0;
  int                  steady_left    = 0;
  int                  mismatch_count = 0;

  sensor_frame_assembler uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_sample_bits (in_sample_bits),
    .out_valid      (out_valid),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shift the payload through the CRC one bit at a time, MSB first; with a
  // zero start value this gives the same checksum as the byte-wise form.
  function automatic logic [7:0] payload_crc(input logic [SAMPLE_W-1:0] word);
    logic [7:0] crc;
    crc = '0;
    for (int b = SAMPLE_W - 1; b >= 0; b--) begin
      crc = {crc[6:0], 1'b0} ^ ((crc[7] ^ word[b]) ? CRC_POLY : 8'h00);
    end
    return crc;
  endfunction

  // Lay out the whole frame as one wide vector, then queue it byte by byte.
  function automatic void assemble_frame(input logic [SAMPLE_W-1:0] word);
    logic [FRAME_BITS-1:0] frame;
    frame_byte_t           fb;
    frame = {regs.delim, 16'(HEADER_LEN), 16'(PAYLOAD_LEN),
             regs.addr_type, 8'(ADDR_LEN), regs.dev_addr,
             regs.dev_type, 8'(EUI_LEN), regs.dev_eui,
             regs.app_type, 8'(EUI_LEN), regs.app_eui,
             word, payload_crc(word), regs.end_mark};
    for (int i = 0; i < FRAME_LEN; i++) begin
      fb.value = frame[FRAME_BITS - 1 - 8 * i -: 8];
      fb.last  = (i == FRAME_LEN - 1);
      expected_bytes.push_back(fb);
    end
  endfunction

  // Mirror one register write: narrow registers drop the high data bits,
  // and an index past the last register changes nothing.
  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
    case (sfa_reg_idx_t'(idx))
      REG_DEVICE_ADDRESS:  regs.dev_addr  = val[31:0];
      REG_DEVICE_EUI:      regs.dev_eui   = val;
      REG_APPLICATION_EUI: regs.app_eui   = val;
      REG_ADDR_TYPE:       regs.addr_type = val[7:0];
      REG_DEV_ID_TYPE:     regs.dev_type  = val[7:0];
      REG_APP_ID_TYPE:     regs.app_type  = val[7:0];
      REG_START_DELIM:     regs.delim     = val[7:0];
      REG_END_MARKER:      regs.end_mark  = val[15:0];
      default: ;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] draw_reg_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly uniform words, with the odd zero, all-ones or single-bit word.
  function automatic logic [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
      default: return $urandom;
    endcase
  endfunction

  // Call right after a rising edge; return right after one as well.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    apply_reg_write(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Write every register, then one index past the end with random data.
  task automatic program_regs(input fill_mode_t mode);
    logic [CFG_DATA_W-1:0] val;
    for (int i = int'(REG_DEVICE_ADDRESS); i <= int'(REG_END_MARKER); i++) begin
      case (mode)
        FILL_ZERO: val = '0;
        FILL_ONES: val = '1;
        default:   val = draw_reg_value();
      endcase
      write_reg(CFG_IDX_W'(i), val);
    end
    write_reg(CFG_IDX_W'($urandom_range(int'(REG_END_MARKER) + 1, (1 << CFG_IDX_W) - 1)),
              {$urandom, $urandom});
  endtask

  // Wait until every queued word is taken and every frame byte has come out,
  // then give the block a few quiet cycles. Check on the falling edge so the
  // driver and monitor have settled for the cycle.
  task automatic drain();
    do begin
      @(negedge clk);
    end while (pending_samples.size() != 0 || start || expected_bytes.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Word driver: hold start and the word until the block takes it, then
  // predict its frame and draw the idle gap before the next word. Now and
  // then run a stretch of words back to back with no gap at all.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        assemble_frame(in_sample_bits);
        if (steady_left > 0) begin
          steady_left--;
          gap_left = 0;
        end else begin
          gap_left = $urandom_range(0, GAP_MAX);
          if ($urandom_range(0, 15) == 0) begin
            steady_left = $urandom_range(8, 24);
          end
        end
      end
      if (start && busy) begin
        // hold: the word has not been taken yet
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        start          <= 1'b1;
        in_sample_bits <= pending_samples.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Byte monitor: every strobe must match the oldest expected byte, both the
  // byte value and the last flag.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_bytes.size() == 0) begin
        mismatch_count++;
        $display("%0t: byte with none expected: expected none, actual %02h last %0b",
                 $time, out_frame_byte, out_last_byte);
      end else begin
        want = expected_bytes.pop_front();
        if (out_frame_byte !== want.value) begin
          mismatch_count++;
          $display("%0t: frame_byte expected %02h, actual %02h",
                   $time, want.value, out_frame_byte);
        end
        if (out_last_byte !== want.last) begin
          mismatch_count++;
          $display("%0t: last_byte expected %0b, actual %0b",
                   $time, want.last, out_last_byte);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: reset, then phases of register settings and words.
  // --------------------------------------------------------------------------
  initial begin
    regs.dev_addr  = '0;
    regs.dev_eui   = '0;
    regs.app_eui   = '0;
    regs.addr_type = '0;
    regs.dev_type  = '0;
    regs.app_type  = '0;
    regs.delim     = START_DELIM_RST;
    regs.end_mark  = END_MARKER_RST;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Run the directed words against the reset values of the registers.
    foreach (DIRECTED_WORDS[i]) begin
      pending_samples.push_back(DIRECTED_WORDS[i]);
    end
    drain();

    // Saturate every register; wide data also checks that high bits drop.
    program_regs(FILL_ONES);
    pending_samples.push_back('0);
    pending_samples.push_back('1);
    repeat (3) pending_samples.push_back(draw_sample());
    drain();

    // Clear every register, including the delimiter and end marker.
    program_regs(FILL_ZERO);
    pending_samples.push_back('0);
    pending_samples.push_back('1);
    pending_samples.push_back(32'h0000_0001);
    drain();

    // Advance through random settings, each with its own batch of words.
    repeat (RAND_PHASES) begin
      program_regs(FILL_RANDOM);
      repeat (RAND_WORDS) pending_samples.push_back(draw_sample());
      drain();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Stop a hung run; the longest correct run takes a small fraction of this.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
